/* hw/rtl/checksummed_frame_receiver_defines.svh */
// ---------------------------------------------------------------------------
// checksummed frame receiver assertion macros
// shared property forms for the port-level checker
// ---------------------------------------------------------------------------
`ifndef CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH
`define CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CFR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define CFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/cfr_pkg.sv */
// ---------------------------------------------------------------------------
// cfr_pkg
// shared constants, result codes and inter-module structs of the receiver
// ---------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

   localparam int PAYLOAD_MAX = 32;
   localparam int ADDR_W      = $clog2(PAYLOAD_MAX);
   localparam int COUNT_W     = $clog2(PAYLOAD_MAX + 4);
   localparam int LEN_W       = 6;

   localparam logic [7:0]         START_MARK    = 8'hFE;
   localparam logic [7:0]         END_MARK      = 8'hFD;
   localparam logic [7:0]         TIMEOUT_RESET = 8'd10;
   localparam logic [COUNT_W-1:0] HEADER_BYTES  = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] FRAME_LIMIT   = COUNT_W'(PAYLOAD_MAX + 3);

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_NACK    = 2'd2
   } kind_type;

   // payload buffer write
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } buf_write_type;

   // frame end event from the parser
   typedef struct packed {
      logic             hdr;
      logic             nack;
      logic [7:0]       command;
      logic [LEN_W-1:0] length;
   } frame_event_type;

endpackage

`default_nettype wire

/* hw/rtl/cfr_payload_ram.sv */
// ---------------------------------------------------------------------------
// cfr_payload_ram
// payload buffer, one write port and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module cfr_payload_ram
   import cfr_pkg::*;
(
   input  wire logic              clock,
   input  wire buf_write_type     wr,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [7:0]        rd_data
);

   logic [7:0] mem [PAYLOAD_MAX];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/cfr_parser.sv */
// ---------------------------------------------------------------------------
// cfr_parser
// preamble hunt, frame field capture, checksum and idle timeout
// ---------------------------------------------------------------------------
`default_nettype none

module cfr_parser
   import cfr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_we,
   input  wire logic [7:0]      csr_wdata,
   input  wire logic            req_fire,
   input  wire logic            req_mode,
   input  wire logic [7:0]      req_rx_byte,
   output      buf_write_type   wr,
   output      frame_event_type evt
);

   logic               in_frame_ff, in_frame_in;
   logic [7:0]         prev_ff, prev_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         sent_sum_ff, sent_sum_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         cmd_ff, cmd_in;
   logic [7:0]         len_ff, len_in;
   logic [7:0]         idle_ff, idle_in;
   logic [7:0]         timeout_ff, timeout_in;
   logic [7:0]         tick_count;
   logic [COUNT_W-1:0] data_idx;
   logic               is_end;

   assign tick_count = idle_ff + 8'd1;
   assign data_idx   = count_ff - HEADER_BYTES;
   // end mark counts only once the length is in and the payload count matches it
   assign is_end     = (req_rx_byte == END_MARK) && (count_ff >= HEADER_BYTES) &&
                       (8'(data_idx) == len_ff);

   always_comb begin
      in_frame_in = in_frame_ff;
      prev_in     = prev_ff;
      count_in    = count_ff;
      sent_sum_in = sent_sum_ff;
      sum_in      = sum_ff;
      cmd_in      = cmd_ff;
      len_in      = len_ff;
      idle_in     = idle_ff;
      timeout_in  = timeout_ff;
      wr          = '0;
      wr.addr     = data_idx[ADDR_W-1:0];
      wr.data     = req_rx_byte;
      evt         = '0;
      evt.command = cmd_ff;
      evt.length  = LEN_W'(data_idx);

      if (csr_we) begin
         timeout_in = csr_wdata;
      end

      if (req_fire) begin
         if (req_mode) begin
            idle_in = tick_count;
            if (tick_count > timeout_ff) begin
               idle_in     = '0;
               count_in    = '0;
               sum_in      = '0;
               prev_in     = '0;
               in_frame_in = 1'b0;
            end
         end else begin
            idle_in = '0;
            prev_in = req_rx_byte;
            if (in_frame_ff) begin
               if (is_end) begin
                  evt.hdr     = (sent_sum_ff == sum_ff);
                  evt.nack    = (sent_sum_ff != sum_ff);
                  count_in    = '0;
                  sum_in      = '0;
                  in_frame_in = 1'b0;
               end else if (count_ff < FRAME_LIMIT) begin
                  case (count_ff)
                     COUNT_W'(0): begin
                        sent_sum_in = req_rx_byte;
                     end
                     COUNT_W'(1): begin
                        cmd_in = req_rx_byte;
                        sum_in = sum_ff + req_rx_byte;
                     end
                     COUNT_W'(2): begin
                        len_in = req_rx_byte;
                        sum_in = sum_ff + req_rx_byte;
                     end
                     default: begin
                        wr.en  = (int'(data_idx) < PAYLOAD_MAX);
                        sum_in = sum_ff + req_rx_byte;
                     end
                  endcase
                  count_in = count_ff + COUNT_W'(1);
               end else begin
                  // overflow, drop the frame silently
                  count_in    = '0;
                  sum_in      = '0;
                  in_frame_in = 1'b0;
               end
            end else if (prev_ff == START_MARK && req_rx_byte == START_MARK) begin
               count_in    = '0;
               sum_in      = '0;
               in_frame_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         prev_ff     <= '0;
         count_ff    <= '0;
         sent_sum_ff <= '0;
         sum_ff      <= '0;
         cmd_ff      <= '0;
         len_ff      <= '0;
         idle_ff     <= '0;
         timeout_ff  <= TIMEOUT_RESET;
      end else begin
         in_frame_ff <= in_frame_in;
         prev_ff     <= prev_in;
         count_ff    <= count_in;
         sent_sum_ff <= sent_sum_in;
         sum_ff      <= sum_in;
         cmd_ff      <= cmd_in;
         len_ff      <= len_in;
         idle_ff     <= idle_in;
         timeout_ff  <= timeout_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/cfr_emitter.sv */
// ---------------------------------------------------------------------------
// cfr_emitter
// result register and payload read-out sequencer
// ---------------------------------------------------------------------------
`default_nettype none

module cfr_emitter
   import cfr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire frame_event_type   evt,
   output      logic              ready_for_word,
   output      logic              rd_en,
   output      logic [ADDR_W-1:0] rd_addr,
   input  wire logic [7:0]        rd_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [1:0]        rsp_kind,
   output      logic [7:0]        rsp_command,
   output      logic [LEN_W-1:0]  rsp_payload_length,
   output      logic [7:0]        rsp_payload_byte,
   output      logic              rsp_last
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_LOAD = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic             valid_ff, valid_in;
   kind_type         kind_ff, kind_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] total_ff, total_in;
   logic             out_free;
   logic [LEN_W-1:0] idx_next;

   assign out_free       = !valid_ff || rsp_ready;
   assign ready_for_word = (state_ff == S_IDLE) && out_free;
   assign idx_next       = idx_ff + LEN_W'(1);
   assign rd_addr        = idx_ff[ADDR_W-1:0];

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      total_in = total_ff;
      rd_en    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (evt.hdr) begin
               valid_in = 1'b1;
               kind_in  = KIND_HEADER;
               cmd_in   = evt.command;
               len_in   = evt.length;
               byte_in  = '0;
               last_in  = (evt.length == '0);
               idx_in   = '0;
               total_in = evt.length;
               if (evt.length != '0) begin
                  state_in = S_READ;
               end
            end else if (evt.nack) begin
               valid_in = 1'b1;
               kind_in  = KIND_NACK;
               cmd_in   = '0;
               len_in   = '0;
               byte_in  = '0;
               last_in  = 1'b1;
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (out_free) begin
               valid_in = 1'b1;
               kind_in  = KIND_PAYLOAD;
               cmd_in   = '0;
               len_in   = '0;
               byte_in  = rd_data;
               last_in  = (idx_next == total_ff);
               idx_in   = idx_next;
               state_in = (idx_next == total_ff) ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      kind_ff  <= kind_in;
      cmd_ff   <= cmd_in;
      len_ff   <= len_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      idx_ff   <= idx_in;
      total_ff <= total_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_command        = cmd_ff;
   assign rsp_payload_length = len_ff;
   assign rsp_payload_byte   = byte_ff;
   assign rsp_last           = last_ff;

endmodule

`default_nettype wire

/* hw/rtl/checksummed_frame_receiver.sv */
// checksummed frame receiver
// the req channel carries one word per received byte (req_mode = 0) or per
// millisecond tick (req_mode = 1); the receiver hunts for two 0xFE bytes,
// then takes checksum, command, length and payload bytes into a 32-byte buffer
// a 0xFD at the right payload count closes the frame: a good sum gives one
// header word then one rsp word per payload byte, a bad sum one nack word
// req words are taken at one per cycle while no frame is being read out and no rsp word is stalled;
// a closing byte puts its first result on rsp the next cycle
// payload read-out does a buffer read, then a result load, for each byte, a split
// forced by the single read port and its registered data; req_ready is low during
// the read-out, which also keeps buffer reads and writes apart
// when rsp stalls, the result register holds and req_ready drops until the
// pending word is taken (a word may be accepted in the cycle it leaves)
// csr_we writes the idle timeout in ticks (reset value 10)
// reset is synchronous: hunting, counters cleared, no result pending; the
// buffer is not cleared, only entries written in the current frame are read
// ---------------------------------------------------------------------------
// checksummed_frame_receiver
// top level: parser, payload buffer and result emitter
// ---------------------------------------------------------------------------
`default_nettype none

module checksummed_frame_receiver
   import cfr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic [7:0]       csr_wdata,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire logic             req_mode,
   input  wire logic [7:0]       req_rx_byte,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      logic [1:0]       rsp_kind,
   output      logic [7:0]       rsp_command,
   output      logic [LEN_W-1:0] rsp_payload_length,
   output      logic [7:0]       rsp_payload_byte,
   output      logic             rsp_last
);

   buf_write_type     wr;
   frame_event_type   evt;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              req_fire;

   // a word is taken only when the emitter is idle and its register is free
   assign req_fire = req_valid && req_ready;

   cfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_fire    (req_fire),
      .req_mode    (req_mode),
      .req_rx_byte (req_rx_byte),
      .wr          (wr),
      .evt         (evt)
   );

   // payload buffer, written while collecting, read during read-out
   cfr_payload_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cfr_emitter u_emitter (
      .clock              (clock),
      .reset              (reset),
      .evt                (evt),
      .ready_for_word     (req_ready),
      .rd_en              (rd_en),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_command        (rsp_command),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

/* hw/rtl/cfr_checker.sv */
// ---------------------------------------------------------------------------
// cfr_checker
// port-level checks on the receiver, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "checksummed_frame_receiver_defines.svh"

module cfr_checker
   import cfr_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             req_mode,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic [1:0]       rsp_kind,
   input wire logic             rsp_last
);

   `CFR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped while stalled")

   `CFR_ASSERT_NOW(a_nack_last, rsp_valid && rsp_kind == KIND_NACK, rsp_last, "nack word not marked last")

   `CFR_ASSERT_NOW(a_hdr_blocks, rsp_valid && rsp_ready && rsp_kind == KIND_HEADER && !rsp_last, !req_ready, "input taken while payload pending")

   `CFR_ASSERT_NOW(a_pay_blocks, rsp_valid && rsp_ready && rsp_kind == KIND_PAYLOAD && !rsp_last, !req_ready, "input taken inside payload burst")

   `CFR_ASSERT_NEXT(a_tick_quiet, req_valid && req_ready && req_mode && !(rsp_valid && !rsp_ready), !rsp_valid, "tick produced a result")

endmodule

bind checksummed_frame_receiver cfr_checker u_cfr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_mode  (req_mode),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_kind  (rsp_kind),
   .rsp_last  (rsp_last)
);

`default_nettype wire
